FILE: hw/rtl/tap_tempo_estimator_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the tap tempo estimator
// Shared property wrappers, clocked on clk and disabled during arst_n low.
// ---------------------------------------------------------------------------
`ifndef TAP_TEMPO_ESTIMATOR_ASSERT_SVH
`define TAP_TEMPO_ESTIMATOR_ASSERT_SVH

// Check a property at every rising edge outside reset
`define TTE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition is followed by a consequence in the next cycle
`define TTE_ASSERT_NEXT(lbl, cond, conseq, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (conseq)) \
		else $error(msg);

`endif

FILE: hw/rtl/tte_pkg.sv
// ---------------------------------------------------------------------------
// tte_pkg
// Field widths, register indexes, reset values and the controller/datapath
// command and status types of the tap tempo estimator.
// ---------------------------------------------------------------------------
`default_nettype none

package tte_pkg;

	// Field widths
	localparam int LEVEL_W    = 8;
	localparam int TPM_W      = 20;
	localparam int BPM_W      = 10;
	localparam int HELD_W     = 4;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 20;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TAP_THRESHOLD    = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_MINUTE = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BPM_MIN          = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BPM_MAX          = 8'd3;

	// Register reset values
	localparam logic [LEVEL_W-1:0] THRESHOLD_RST = 8'd128;
	localparam logic [TPM_W-1:0]   TPM_RST       = 20'd60000;
	localparam logic [BPM_W-1:0]   BPM_MIN_RST   = 10'd1;
	localparam logic [BPM_W-1:0]   BPM_MAX_RST   = 10'd300;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic tick;
		logic drop;
		logic sum_start;
		logic sum_step;
		logic decide;
		logic div_start;
		logic div_step;
		logic load_out;
	} tte_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic tap;
		logic sum_done;
		logic est_ok;
		logic div_done;
		logic in_range;
	} tte_sts_t;

endpackage

`default_nettype wire

FILE: hw/rtl/tte_ifs.sv
// ---------------------------------------------------------------------------
// Tap tempo estimator channels
// Valid/ready channels for tap ticks, tempo estimates and register writes.
// ---------------------------------------------------------------------------
`default_nettype none

// Tick channel: one word per time tick
interface tte_tap_if import tte_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [LEVEL_W-1:0] tap_level;

	modport source (output valid, output tap_level, input ready);
	modport sink (input valid, input tap_level, output ready);
endinterface

// Estimate channel: one word per emitted tempo
interface tte_est_if import tte_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BPM_W-1:0]  bpm;
	logic [HELD_W-1:0] intervals_held;

	modport source (output valid, output bpm, output intervals_held, input ready);
	modport sink (input valid, input bpm, input intervals_held, output ready);
endinterface

// Register write channel
interface tte_cfg_if import tte_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/tte_ram.sv
// ---------------------------------------------------------------------------
// tte_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
`default_nettype none

module tte_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 9
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/tte_datapath.sv
// ---------------------------------------------------------------------------
// tte_datapath
// Tick timer, tap detection, interval history, tail sum, outlier test,
// serial divider and result register of the tap tempo estimator.
// ---------------------------------------------------------------------------
`default_nettype none
`include "tap_tempo_estimator_assert.svh"

module tte_datapath import tte_pkg::*; #(
	parameter int HISTORY_DEPTH = 9,
	parameter int TIMER_BITS    = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire tte_cmd_t              cmd,
	output tte_sts_t                   sts,
	input  wire logic [LEVEL_W-1:0]    tap_level,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output logic      [BPM_W-1:0]      bpm,
	output logic      [HELD_W-1:0]     intervals_held
);

	localparam int PTR_W  = $clog2(HISTORY_DEPTH);
	localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
	localparam int SUM_W  = TIMER_BITS + PTR_W;
	localparam int PROD_W = SUM_W + 1;
	localparam int CMP_W  = SUM_W + 2;
	localparam int NUM_W  = TPM_W + PTR_W;
	localparam int DCNT_W = $clog2(NUM_W + 1);

	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(HISTORY_DEPTH);
	localparam logic [PTR_W:0]   DEPTH_PTR = (PTR_W + 1)'(HISTORY_DEPTH);

	// Configuration registers
	logic [LEVEL_W-1:0] threshold_q;
	logic [TPM_W-1:0]   tpm_q;
	logic [BPM_W-1:0]   bpm_min_q;
	logic [BPM_W-1:0]   bpm_max_q;

	// Tick and history state
	logic [TIMER_BITS-1:0] timer_q;
	logic                  armed_q;
	logic [TIMER_BITS-1:0] interval_q;
	logic [PTR_W-1:0]      head_q;
	logic [CNT_W-1:0]      count_q;

	// Sum pass
	logic [CNT_W-1:0] idx_q;
	logic             pend_q;
	logic [SUM_W-1:0] sum_q;
	logic [PROD_W-1:0] prod_q;

	// Divider
	logic [NUM_W-1:0]  quo_q;
	logic [SUM_W-1:0]  rem_q;
	logic [DCNT_W-1:0] div_cnt_q;

	// Result payload
	logic [BPM_W-1:0]  bpm_q;
	logic [HELD_W-1:0] held_q;

	logic [TIMER_BITS-1:0] timer_inc;
	logic                  pressed;
	logic [PTR_W-1:0]      d_w;
	logic [SUM_W-1:0]      mul_w;
	logic [CMP_W-1:0]      sum3_w;
	logic                  clear_w;
	logic                  rd_en;
	logic [PTR_W-1:0]      rd_addr;
	logic                  wr_en;
	logic [PTR_W-1:0]      wr_addr;
	logic [TIMER_BITS-1:0] rd_data;
	logic [SUM_W:0]        r_next;
	logic                  r_ge;

	// Map a history position onto a RAM address behind the oldest entry
	function automatic logic [PTR_W-1:0] phys(input logic [PTR_W-1:0] head,
	                                          input logic [PTR_W-1:0] pos);
		logic [PTR_W:0] s;
		s = {1'b0, head} + {1'b0, pos};
		if (s >= DEPTH_PTR) begin
			s = s - DEPTH_PTR;
		end
		return s[PTR_W-1:0];
	endfunction

	assign cfg_ready = 1'b1;

	// Write configuration registers; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RST;
			tpm_q       <= TPM_RST;
			bpm_min_q   <= BPM_MIN_RST;
			bpm_max_q   <= BPM_MAX_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_TAP_THRESHOLD:    threshold_q <= cfg_data[LEVEL_W-1:0];
				REG_TICKS_PER_MINUTE: tpm_q       <= cfg_data[TPM_W-1:0];
				REG_BPM_MIN:          bpm_min_q   <= cfg_data[BPM_W-1:0];
				REG_BPM_MAX:          bpm_max_q   <= cfg_data[BPM_W-1:0];
				default: ;
			endcase
		end
	end

	// Tap detection on the current word
	assign timer_inc = (timer_q == '1) ? timer_q : timer_q + 1'b1;
	assign pressed   = (tap_level >= threshold_q);
	assign sts.tap   = pressed && !armed_q;

	// Advance the timer, track the arm flag, capture the interval on a tap
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timer_q <= '0;
			armed_q <= 1'b0;
		end else if (cmd.tick) begin
			armed_q <= pressed;
			timer_q <= sts.tap ? '0 : timer_inc;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.tick && sts.tap) begin
			interval_q <= timer_inc;
		end
	end

	// Divisor count and outlier test
	assign d_w     = PTR_W'(count_q - 1'b1);
	assign mul_w   = SUM_W'(interval_q) * SUM_W'(d_w);
	assign sum3_w  = {2'b00, sum_q} + {1'b0, sum_q, 1'b0};
	assign clear_w = (count_q > CNT_W'(2)) && (sum_q > SUM_W'(d_w)) &&
	                 (({1'b0, prod_q} > sum3_w) || (prod_q < {1'b0, sum_q}));

	always_ff @(posedge clk) begin
		prod_q <= {mul_w, 1'b0};
	end

	// History bookkeeping: drop the oldest when full, clear or append
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else if (cmd.drop) begin
			if (count_q >= DEPTH_CNT) begin
				head_q  <= phys(head_q, PTR_W'(1));
				count_q <= DEPTH_CNT - 1'b1;
			end
		end else if (cmd.decide) begin
			count_q <= clear_w ? '0 : count_q + 1'b1;
		end
	end

	assign wr_en   = cmd.decide && !clear_w;
	assign wr_addr = phys(head_q, count_q[PTR_W-1:0]);
	assign rd_en   = cmd.sum_step && (idx_q < count_q);
	assign rd_addr = phys(head_q, idx_q[PTR_W-1:0]);

	tte_ram #(
		.WIDTH (TIMER_BITS),
		.DEPTH (HISTORY_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (interval_q),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	// Sum pass over entries one to count-1, then fold in the new interval
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			pend_q <= 1'b0;
		end else if (cmd.sum_start) begin
			idx_q  <= CNT_W'(1);
			pend_q <= 1'b0;
		end else if (cmd.sum_step) begin
			pend_q <= rd_en;
			if (rd_en) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sum_start) begin
			sum_q <= '0;
		end else if (cmd.sum_step && pend_q) begin
			sum_q <= sum_q + SUM_W'(rd_data);
		end else if (wr_en) begin
			sum_q <= (count_q != '0) ? sum_q + SUM_W'(interval_q) : '0;
		end
	end

	assign sts.sum_done = (idx_q >= count_q) && !pend_q;
	assign sts.est_ok   = (count_q > CNT_W'(2)) && (sum_q != '0);

	// Restoring divider, one quotient bit a cycle
	assign r_next = {rem_q, quo_q[NUM_W-1]};
	assign r_ge   = (r_next >= {1'b0, sum_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (cmd.div_start) begin
			div_cnt_q <= '0;
		end else if (cmd.div_step) begin
			div_cnt_q <= div_cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			quo_q <= NUM_W'(tpm_q) * NUM_W'(d_w);
			rem_q <= '0;
		end else if (cmd.div_step) begin
			quo_q <= {quo_q[NUM_W-2:0], r_ge};
			rem_q <= r_ge ? SUM_W'(r_next - {1'b0, sum_q}) : SUM_W'(r_next);
		end
	end

	assign sts.div_done = (div_cnt_q == DCNT_W'(NUM_W));
	assign sts.in_range = (quo_q >= NUM_W'(bpm_min_q)) && (quo_q <= NUM_W'(bpm_max_q));

	// Result payload
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			bpm_q  <= quo_q[BPM_W-1:0];
			held_q <= HELD_W'(count_q);
		end
	end

	assign bpm            = bpm_q;
	assign intervals_held = held_q;

	`TTE_ASSERT(a_count_bounded, count_q <= DEPTH_CNT, "history count beyond depth")
	`TTE_ASSERT(a_head_bounded, {1'b0, head_q} < DEPTH_PTR, "head pointer beyond depth")
	`TTE_ASSERT(a_div_nonzero, cmd.div_step |-> (sum_q != '0), "divide by zero sum")

endmodule

`default_nettype wire

FILE: hw/rtl/tte_ctrl.sv
// ---------------------------------------------------------------------------
// tte_ctrl
// Sequencer of the tap tempo estimator: tick handshake, tap processing
// steps and the output valid flag.
// ---------------------------------------------------------------------------
`default_nettype none
`include "tap_tempo_estimator_assert.svh"

module tte_ctrl import tte_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  wire logic     out_ready,
	input  wire tte_sts_t sts,
	output tte_cmd_t      cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DROP   = 3'd1;
	localparam logic [2:0] S_SUM    = 3'd2;
	localparam logic [2:0] S_DECIDE = 3'd3;
	localparam logic [2:0] S_CHECK  = 3'd4;
	localparam logic [2:0] S_DIV    = 3'd5;
	localparam logic [2:0] S_RANGE  = 3'd6;
	localparam logic [2:0] S_EMIT   = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       slot_free;

	assign in_ready  = (state_q == S_IDLE);
	assign slot_free = !out_valid_q || out_ready;

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.tick = 1'b1;
					if (sts.tap) begin
						state_d = S_DROP;
					end
				end
			end
			S_DROP: begin
				cmd.drop      = 1'b1;
				cmd.sum_start = 1'b1;
				state_d       = S_SUM;
			end
			S_SUM: begin
				if (sts.sum_done) begin
					state_d = S_DECIDE;
				end else begin
					cmd.sum_step = 1'b1;
				end
			end
			S_DECIDE: begin
				cmd.decide = 1'b1;
				state_d    = S_CHECK;
			end
			S_CHECK: begin
				if (sts.est_ok) begin
					cmd.div_start = 1'b1;
					state_d       = S_DIV;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_DIV: begin
				if (sts.div_done) begin
					state_d = S_RANGE;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			S_RANGE: begin
				state_d = sts.in_range ? S_EMIT : S_IDLE;
			end
			S_EMIT: begin
				if (slot_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Hold the result word until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	`TTE_ASSERT_NEXT(a_tap_starts, in_valid && in_ready && sts.tap, state_q == S_DROP, "tap not processed")
	`TTE_ASSERT(a_no_overwrite, cmd.load_out |-> slot_free, "result overwritten before taken")
	`TTE_ASSERT_NEXT(a_emit_waits, state_q == S_EMIT && !slot_free, state_q == S_EMIT, "result lost")

endmodule

`default_nettype wire

FILE: hw/rtl/tap_tempo_estimator.sv
// ---------------------------------------------------------------------------
// tap_tempo_estimator
// Tap tempo from the mean of recent tap intervals; outside tap processing, one tick word per cycle.
// ---------------------------------------------------------------------------
// Each word on taps is one time tick. A tick that is not a tap is taken
// without a stall. A tap (level reaching the threshold while not armed)
// stops the tick channel while it is processed: a drop of the oldest
// interval when the history is full, a sum pass over the held history
// through the single RAM read port, the outlier test and append, a check
// that the history yields an estimate, then the serial divider at one
// quotient bit a cycle, a range check and an output load. A tempo result
// sits in an output register; ticks keep flowing while it waits, and only
// the load of the next result waits for it to be taken.
// ---------------------------------------------------------------------------
`default_nettype none

module tap_tempo_estimator import tte_pkg::*; #(
	parameter int HISTORY_DEPTH = 9,
	parameter int TIMER_BITS    = 16
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	tte_tap_if.sink    taps,
	tte_est_if.source  estimate,
	tte_cfg_if.sink    cfg
);

	tte_cmd_t cmd;
	tte_sts_t sts;

	// Sequencer
	tte_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (taps.valid),
		.in_ready  (taps.ready),
		.out_valid (estimate.valid),
		.out_ready (estimate.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Datapath
	tte_datapath #(
		.HISTORY_DEPTH (HISTORY_DEPTH),
		.TIMER_BITS    (TIMER_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.tap_level      (taps.tap_level),
		.cfg_valid      (cfg.valid),
		.cfg_ready      (cfg.ready),
		.cfg_index      (cfg.index),
		.cfg_data       (cfg.data),
		.bpm            (estimate.bpm),
		.intervals_held (estimate.intervals_held)
	);

endmodule

`default_nettype wire

FILE: bench/tap_tempo_estimator_test.sv
// ---------------------------------------------------------------------------
// tap_tempo_estimator_test
// Self-checking bench for the tap tempo estimator. Tick words are fed in
// bursts with random gaps; a local tempo model predicts each estimate word,
// which is checked field by field against the estimate channel while the
// receiver stalls on its own pattern. Register writes happen only with the
// block drained.
// ---------------------------------------------------------------------------
`default_nettype none

module tap_tempo_estimator_test import tte_pkg::*; ();

	localparam int HIST_DEPTH    = 9;
	localparam int TMR_BITS      = 16;
	localparam int SETTLE_CYCLES = 64;
	localparam int QUIET_LIMIT   = 4000;
	localparam int ERR_SHOW      = 10;
	localparam int RANDOM_TICKS  = 80;

	localparam logic [TMR_BITS-1:0] TMR_MAX = '1;

	// Indexes that decode to no register
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 8'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 8'd255;

	typedef enum logic [1:0] {
		READY_ALWAYS,
		READY_COIN,
		READY_PERIODIC,
		READY_SPARSE
	} ready_mode_t;

	typedef struct packed {
		logic [BPM_W-1:0]  bpm;
		logic [HELD_W-1:0] held;
	} tempo_t;

	logic clk;
	logic arst_n;

	tte_tap_if taps ();
	tte_est_if estimate ();
	tte_cfg_if cfg ();

	tap_tempo_estimator #(
		.HISTORY_DEPTH (HIST_DEPTH),
		.TIMER_BITS    (TMR_BITS)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.taps     (taps),
		.estimate (estimate),
		.cfg      (cfg)
	);

	// Tempo model state and register copies
	logic [TMR_BITS-1:0] hist [HIST_DEPTH];
	int unsigned         hist_n;
	logic [TMR_BITS-1:0] tick_count;
	logic                armed;
	logic [LEVEL_W-1:0]  thr_reg;
	logic [TPM_W-1:0]    tpm_reg;
	logic [BPM_W-1:0]    bpm_lo_reg;
	logic [BPM_W-1:0]    bpm_hi_reg;

	tempo_t pending_tempos [$];

	int unsigned error_count;
	int unsigned ticks_sent;
	int unsigned burst_left;
	int unsigned quiet_cycles;

	tempo_t want_tempo;
	tempo_t got_tempo;

	// Clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic longint unsigned hist_tail_sum();
		longint unsigned s = 0;
		for (int i = 1; i < hist_n; i++)
			s += hist[i];
		return s;
	endfunction

	// Fold one tap interval into the history and queue any estimate it yields
	function automatic void register_tap(input logic [TMR_BITS-1:0] span);
		longint unsigned s;
		longint unsigned d;
		longint unsigned twice;
		longint unsigned tempo;
		logic            wipe;
		tempo_t          t;
		wipe = 1'b0;
		if (hist_n >= HIST_DEPTH) begin
			for (int i = 1; i < HIST_DEPTH; i++)
				hist[i-1] = hist[i];
			hist_n = HIST_DEPTH - 1;
		end
		// Outlier test against the mean of all but the oldest entry
		if (hist_n > 2) begin
			s = hist_tail_sum();
			d = hist_n - 1;
			twice = 2 * span * d;
			if (s > d && (twice > 3 * s || twice < s))
				wipe = 1'b1;
		end
		if (wipe) begin
			hist_n = 0;
		end else begin
			hist[hist_n] = span;
			hist_n++;
		end
		tick_count = '0;
		if (hist_n > 2) begin
			s = hist_tail_sum();
			d = hist_n - 1;
			if (s != 0) begin
				tempo = tpm_reg * d / s;
				if (tempo >= bpm_lo_reg && tempo <= bpm_hi_reg) begin
					t.bpm = tempo[BPM_W-1:0];
					t.held = HELD_W'(hist_n);
					pending_tempos.push_back(t);
				end
			end
		end
	endfunction

	// Advance the model by one accepted tick word
	function automatic void predict_tick(input logic [LEVEL_W-1:0] lvl);
		if (tick_count != TMR_MAX)
			tick_count++;
		if (lvl >= thr_reg) begin
			if (!armed) begin
				armed = 1'b1;
				register_tap(tick_count);
			end
		end else begin
			armed = 1'b0;
		end
	endfunction

	function automatic logic [LEVEL_W-1:0] pressed_level();
		case ($urandom_range(0, 7))
			0, 1: return thr_reg;
			2: return 8'hFF;
			default: return LEVEL_W'($urandom_range(255, thr_reg));
		endcase
	endfunction

	// With a zero threshold no level releases, so hold the line low anyway
	function automatic logic [LEVEL_W-1:0] released_level();
		if (thr_reg == 0)
			return '0;
		case ($urandom_range(0, 7))
			0, 1: return thr_reg - 1'b1;
			2: return '0;
			default: return LEVEL_W'($urandom_range(0, thr_reg - 1));
		endcase
	endfunction

	task automatic flag_error(input string what, input tempo_t want, input tempo_t got);
		error_count++;
		if (error_count <= ERR_SHOW)
			$display("%0t %s: expected bpm %0d held %0d, got bpm %0d held %0d",
				$time, what, want.bpm, want.held, got.bpm, got.held);
	endtask

	// Send one tick word, then maybe drop valid for a gap between bursts
	task automatic send_tick(input logic [LEVEL_W-1:0] lvl);
		int unsigned gap;
		taps.valid <= 1'b1;
		taps.tap_level <= lvl;
		do @(posedge clk); while (taps.ready !== 1'b1);
		predict_tick(lvl);
		ticks_sent++;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			if (gap > 0) begin
				taps.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end else begin
			burst_left--;
		end
	endtask

	// Tap after the given number of ticks since the previous tap word
	task automatic tap_after(input int unsigned span);
		int unsigned held_extra;
		int unsigned lows;
		if (span < 2)
			span = 2;
		held_extra = (span > 3) ? $urandom_range(0, 2) : 0;
		lows = span - 1 - held_extra;
		repeat (held_extra) send_tick(pressed_level());
		repeat (lows) send_tick(released_level());
		send_tick(pressed_level());
	endtask

	task automatic hold_until_drained();
		taps.valid <= 1'b0;
		while (pending_tempos.size() != 0) @(posedge clk);
	endtask

	// Drain, then give a tap that yields no word time to finish
	task automatic settle();
		hold_until_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= val;
		do @(posedge clk); while (cfg.ready !== 1'b1);
		cfg.valid <= 1'b0;
		case (idx)
			REG_TAP_THRESHOLD: thr_reg = val[LEVEL_W-1:0];
			REG_TICKS_PER_MINUTE: tpm_reg = val[TPM_W-1:0];
			REG_BPM_MIN: bpm_lo_reg = val[BPM_W-1:0];
			REG_BPM_MAX: bpm_hi_reg = val[BPM_W-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// Rewrite every register; junk in the unused upper data bits
	task automatic set_tempo_regs(input logic [LEVEL_W-1:0] thr, input logic [TPM_W-1:0] tpm,
			input logic [BPM_W-1:0] lo, input logic [BPM_W-1:0] hi);
		settle();
		write_reg(REG_TAP_THRESHOLD, CFG_DATA_W'({$urandom(), thr}));
		write_reg(REG_TICKS_PER_MINUTE, tpm);
		write_reg(REG_BPM_MIN, CFG_DATA_W'({$urandom(), lo}));
		write_reg(REG_BPM_MAX, CFG_DATA_W'({$urandom(), hi}));
	endtask

	// Reset values: threshold edge and the top of the default window
	task automatic test_reset_values();
		send_tick(8'd127);
		send_tick(8'd128);
		repeat (2) tap_after(200);
	endtask

	// Clear above and below the mean, keep exactly on both limits
	task automatic test_outlier_rules();
		set_tempo_regs(8'd100, 20'd600, 10'd1, 10'd1023);
		repeat (4) tap_after(6);
		tap_after(10);
		repeat (4) tap_after(6);
		tap_after(9);
		repeat (3) tap_after(6);
		tap_after(2);
		repeat (4) tap_after(6);
		tap_after(3);
	endtask

	task automatic test_history_wrap();
		repeat (12) tap_after(4);
	endtask

	task automatic test_tempo_window();
		// Empty window
		set_tempo_regs(8'd128, 20'd600, 10'd500, 10'd400);
		repeat (4) tap_after(3);
		// Zero rate gives zero tempo, passed only with a zero floor
		set_tempo_regs(8'd128, 20'd0, 10'd0, 10'd1023);
		repeat (4) tap_after(3);
		settle();
		write_reg(REG_BPM_MIN, 20'd1);
		repeat (3) tap_after(3);
		// Top of the range, then a tempo just past it
		set_tempo_regs(8'd128, 20'd3069, 10'd1023, 10'd1023);
		repeat (4) tap_after(3);
		tap_after(2);
		set_tempo_regs(8'd128, 20'd1000000, 10'd1, 10'd1023);
		repeat (3) tap_after(4);
		set_tempo_regs(8'd128, 20'd1, 10'd0, 10'd1);
		repeat (3) tap_after(2);
		set_tempo_regs(8'd128, 20'd10, 10'd1, 10'd1);
		repeat (4) tap_after(10);
	endtask

	task automatic test_threshold_extremes();
		set_tempo_regs(8'd0, 20'd600, 10'd1, 10'd1023);
		repeat (4) begin
			send_tick(8'd0);
			send_tick(8'd255);
		end
		set_tempo_regs(8'd255, 20'd600, 10'd1, 10'd1023);
		send_tick(8'd254);
		repeat (4) tap_after(5);
	endtask

	task automatic test_unknown_index();
		settle();
		write_reg(REG_SPARE_LO, CFG_DATA_W'($urandom()));
		write_reg(REG_SPARE_HI, '1);
		repeat (4) tap_after(5);
	endtask

	task automatic test_random_tempos();
		int unsigned      first_tick;
		int unsigned      span;
		int unsigned      target;
		int unsigned      phases;
		logic [LEVEL_W-1:0] thr;
		logic [TPM_W-1:0]   tpm;
		logic [BPM_W-1:0]   lo;
		logic [BPM_W-1:0]   hi;
		first_tick = ticks_sent;
		phases = 0;
		while (ticks_sent - first_tick < RANDOM_TICKS && phases < 200) begin
			phases++;
			span = $urandom_range(2, 12);
			case ($urandom_range(0, 9))
				0: thr = 8'hFF;
				1: thr = 8'd1;
				default: thr = LEVEL_W'($urandom_range(1, 255));
			endcase
			case ($urandom_range(0, 9))
				0: begin
					lo = BPM_W'($urandom_range(512, 1023));
					hi = BPM_W'($urandom_range(1, 511));
				end
				1: begin
					lo = 10'd1;
					hi = 10'd1023;
				end
				default: begin
					lo = BPM_W'($urandom_range(1, 100));
					hi = BPM_W'($urandom_range(200, 1023));
				end
			endcase
			// Aim the rate so that steady taps land inside the window
			target = (lo <= hi) ? $urandom_range(hi, lo) : $urandom_range(1, 1023);
			if ($urandom_range(0, 9) == 0)
				tpm = TPM_W'($urandom_range(1, 1000000));
			else
				tpm = TPM_W'(target * span + $urandom_range(0, span - 1));
			set_tempo_regs(thr, tpm, lo, hi);
			repeat ($urandom_range(3, 8)) begin
				case ($urandom_range(0, 19))
					0, 1: tap_after($urandom_range(2, 4 * span));
					2: begin
						repeat ($urandom_range(1, 6))
							send_tick(LEVEL_W'($urandom_range(0, 255)));
						tap_after(span);
					end
					3: begin
						hold_until_drained();
						tap_after(span);
					end
					default: tap_after(span - span / 4 + $urandom_range(0, 2 * (span / 4)));
				endcase
			end
		end
	endtask

	// Receiver: switch at random between stall patterns
	initial begin
		ready_mode_t mode;
		int unsigned mode_left;
		int unsigned phase;
		estimate.ready <= 1'b0;
		mode = READY_ALWAYS;
		mode_left = 0;
		phase = 0;
		forever begin
			@(posedge clk);
			if (mode_left == 0) begin
				mode = ready_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(40, 400);
			end else begin
				mode_left--;
			end
			phase++;
			case (mode)
				READY_ALWAYS: estimate.ready <= 1'b1;
				READY_COIN: estimate.ready <= 1'($urandom_range(0, 1));
				READY_PERIODIC: estimate.ready <= (phase % 16) < 4;
				default: estimate.ready <= ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	// Check each estimate word against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && estimate.valid === 1'b1 && estimate.ready === 1'b1) begin
			got_tempo.bpm = estimate.bpm;
			got_tempo.held = estimate.intervals_held;
			if (pending_tempos.size() == 0) begin
				flag_error("tempo word with none pending", '0, got_tempo);
			end else begin
				want_tempo = pending_tempos.pop_front();
				if (got_tempo.bpm !== want_tempo.bpm || got_tempo.held !== want_tempo.held)
					flag_error("tempo word mismatch", want_tempo, got_tempo);
			end
		end
	end

	// Watchdog: end the run after too long with no word moving anywhere
	initial begin
		quiet_cycles = 0;
		while (quiet_cycles < QUIET_LIMIT) begin
			@(posedge clk);
			if ((taps.valid === 1'b1 && taps.ready === 1'b1)
					|| (estimate.valid === 1'b1 && estimate.ready === 1'b1)
					|| (cfg.valid === 1'b1 && cfg.ready === 1'b1))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("tap_tempo_estimator_test: errors");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		taps.valid <= 1'b0;
		taps.tap_level <= '0;
		cfg.valid <= 1'b0;
		cfg.index <= '0;
		cfg.data <= '0;
		hist_n = 0;
		tick_count = '0;
		armed = 1'b0;
		thr_reg = 8'd128;
		tpm_reg = 20'd60000;
		bpm_lo_reg = 10'd1;
		bpm_hi_reg = 10'd300;
		error_count = 0;
		ticks_sent = 0;
		burst_left = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values();
		test_outlier_rules();
		test_history_wrap();
		test_tempo_window();
		test_threshold_extremes();
		test_unknown_index();
		test_random_tempos();
		settle();

		if (error_count == 0 && pending_tempos.size() == 0)
			$display("tap_tempo_estimator_test: clean");
		else
			$display("tap_tempo_estimator_test: errors");
		$finish;
	end

endmodule

`default_nettype wire

FILE: files.f
+incdir+hw/rtl
hw/rtl/tte_pkg.sv
hw/rtl/tte_ifs.sv
hw/rtl/tte_ram.sv
hw/rtl/tte_datapath.sv
hw/rtl/tte_ctrl.sv
hw/rtl/tap_tempo_estimator.sv
bench/tap_tempo_estimator_test.sv
